FILE: rtl/brt_pkg.sv
// Package: types and constants shared by the ball return tracking block.
package brt_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DISPENSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT_TMO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEED_TMO      = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TRANSIT_TMO_RST = 16'd5000;
  localparam logic [15:0] FEED_TMO_RST    = 16'd7000;

  // Item commands
  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COUNT   = 4'd1,
    PH_RDY_ENT = 4'd2,
    PH_READY   = 4'd3,
    PH_TR_ENT  = 4'd4,
    PH_TRANSIT = 4'd5,
    PH_HOLED   = 4'd6,
    PH_GUTTER  = 4'd7,
    PH_STUCK   = 4'd8
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic        departure_event;
    logic        hole_event;
    logic        gutter_event;
  } in_item_t;

  typedef struct packed {
    logic       hole_return_request;
    logic       player_return_request;
    logic [7:0] hit_count;
    logic [7:0] holed_count;
    logic [3:0] phase_now;
  } out_item_t;

  typedef struct packed {
    logic        auto_dispense;
    logic [15:0] transit_timeout_ms;
    logic [15:0] feed_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  hits;
    logic [7:0]  holed;
    logic [31:0] transit_start;
    logic [31:0] feed_start;
    logic        departure_flag;
    logic        hole_flag;
    logic        gutter_flag;
  } state_t;

endpackage

FILE: rtl/brt_in_if.sv
// Interface: input item channel with valid/ready handshake.
interface brt_in_if;
  logic               valid;
  logic               ready;
  brt_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/brt_out_if.sv
// Interface: result item channel with valid/ready handshake.
interface brt_out_if;
  logic               valid;
  logic               ready;
  brt_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: rtl/brt_step.sv
// Module: one controller step, combinational next state and result.
module brt_step (
  input  brt_pkg::state_t    st,
  input  brt_pkg::cfg_t      cfg,
  input  brt_pkg::in_item_t  item,
  output brt_pkg::state_t    st_next,
  output brt_pkg::out_item_t res
);
  import brt_pkg::*;

  logic        dep;
  logic        hol;
  logic        gut;
  logic [7:0]  holed_inc;
  logic        transit_tmo;
  logic        feed_tmo;

  // Sticky flags after this item's pulses
  assign dep = st.departure_flag | item.departure_event;
  assign hol = st.hole_flag | item.hole_event;
  assign gut = st.gutter_flag | item.gutter_event;

  assign holed_inc = st.holed + 8'd1;

  // Wrapping elapsed time against the timeout registers
  assign transit_tmo = (item.now_ms - st.transit_start) > {16'd0, cfg.transit_timeout_ms};
  assign feed_tmo    = (item.now_ms - st.feed_start) > {16'd0, cfg.feed_timeout_ms};

  // Phase step
  always_comb begin
    st_next = st;
    res     = '0;
    if (item.cmd == CMD_CLEAR) begin
      st_next.hits  = 8'd0;
      st_next.holed = 8'd0;
    end else begin
      st_next.departure_flag = dep;
      st_next.hole_flag      = hol;
      st_next.gutter_flag    = gut;
      unique case (st.phase)
        PH_IDLE: begin
          st_next.phase = cfg.auto_dispense ? PH_RDY_ENT : PH_COUNT;
        end
        PH_COUNT: begin
          if (cfg.auto_dispense) begin
            st_next.phase = PH_RDY_ENT;
          end else begin
            if (dep) begin
              st_next.hits           = st.hits + 8'd1;
              st_next.departure_flag = 1'b0;
            end
            if (hol) begin
              st_next.hole_flag       = 1'b0;
              res.hole_return_request = 1'b1;
              // holes never run ahead of hits
              st_next.holed = (holed_inc > st_next.hits) ? st_next.hits : holed_inc;
            end
          end
        end
        PH_RDY_ENT: begin
          st_next.departure_flag = 1'b0;
          if (cfg.auto_dispense) begin
            res.player_return_request = 1'b1;
            st_next.phase             = PH_READY;
          end else begin
            st_next.phase = PH_COUNT;
          end
        end
        PH_READY: begin
          if (dep) begin
            st_next.hits           = st.hits + 8'd1;
            st_next.departure_flag = 1'b0;
            st_next.transit_start  = item.now_ms;
            st_next.phase          = PH_TR_ENT;
          end
        end
        PH_TR_ENT: begin
          st_next.hole_flag   = 1'b0;
          st_next.gutter_flag = 1'b0;
          st_next.phase       = PH_TRANSIT;
        end
        PH_TRANSIT: begin
          if (hol) begin
            st_next.holed     = holed_inc;
            st_next.hole_flag = 1'b0;
            st_next.phase     = PH_HOLED;
          end else if (gut) begin
            // gutter flag stays set for the wait phase
            st_next.feed_start = item.now_ms;
            st_next.phase      = PH_GUTTER;
          end else if (transit_tmo) begin
            st_next.phase = PH_STUCK;
          end
        end
        PH_HOLED: begin
          res.hole_return_request = 1'b1;
          st_next.feed_start      = item.now_ms;
          st_next.phase           = PH_GUTTER;
        end
        PH_GUTTER: begin
          if (gut) begin
            st_next.gutter_flag = 1'b0;
            st_next.phase       = PH_RDY_ENT;
          end else if (feed_tmo) begin
            st_next.phase = PH_RDY_ENT;
          end
        end
        PH_STUCK: begin
          st_next.phase = PH_RDY_ENT;
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
    res.hit_count   = st_next.hits;
    res.holed_count = st_next.holed;
    res.phase_now   = st_next.phase;
  end

endmodule

FILE: rtl/ball_return_tracking_fsm.sv
// Throughput: one item per cycle unless the result side stalls; the step
// logic sits between the input register and the result register, and the
// state updates on the same edge.
// Stalls on the result side back up through one input register stage.
// Reset (rst, synchronous): phase idle, counters and flags zero, timeouts
// 5000 and 7000 ms, auto dispense off, both channels empty.
module ball_return_tracking_fsm (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [brt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brt_pkg::CFG_DATA_W-1:0]     cfg_data,
  brt_in_if.sink                             in_ch,
  brt_out_if.source                          out_ch
);
  import brt_pkg::*;

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  in_item_t  in_q;
  logic      in_valid;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid;
  logic      out_free;
  logic      step_fire;

  // Handshake
  assign out_free    = !out_valid || out_ch.ready;
  assign step_fire   = in_valid && out_free;
  assign in_ch.ready = !in_valid || out_free;
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_dispense      <= 1'b0;
      cfg.transit_timeout_ms <= TRANSIT_TMO_RST;
      cfg.feed_timeout_ms    <= FEED_TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_DISPENSE: cfg.auto_dispense      <= cfg_data[0];
        CFG_TRANSIT_TMO:   cfg.transit_timeout_ms <= cfg_data;
        CFG_FEED_TMO:      cfg.feed_timeout_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step logic
  brt_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_q),
    .st_next (st_next),
    .res     (res)
  );

  // Controller state and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      // all zero: phase idle, counters, starts and flags cleared
      st        <= '0;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid <= in_ch.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (step_fire) begin
        st <= st_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.item;
    end
    if (step_fire) begin
      out_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // A player request only comes out when the ready phase is entered
  a_player_req: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.player_return_request) |-> (out_q.phase_now == PH_READY))
    else $error("player request outside ready entry");

  // A hole request only from counting or from holed into gutter wait
  a_hole_req: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.hole_return_request) |->
      (out_q.phase_now == PH_COUNT || out_q.phase_now == PH_GUTTER))
    else $error("hole request in wrong phase");

  // A clear item leaves both counters at zero
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (step_fire && in_q.cmd == CMD_CLEAR) |=>
      (out_q.hit_count == 8'd0 && out_q.holed_count == 8'd0))
    else $error("clear did not zero counters");

  // The result shows the state that the step left behind
  a_state_match: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> (out_q.phase_now == st.phase && out_q.hit_count == st.hits))
    else $error("result and state disagree");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking bench for the ball return tracking controller: directed table, then random phases.
module tb;
  import brt_pkg::*;

  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Sensor pulse sets, ordered departure, hole, gutter
  localparam logic [2:0] EV_NONE = 3'b000;
  localparam logic [2:0] EV_DEP  = 3'b100;
  localparam logic [2:0] EV_HOLE = 3'b010;
  localparam logic [2:0] EV_GUT  = 3'b001;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  brt_in_if  in_ch ();
  brt_out_if out_ch ();

  ball_return_tracking_fsm DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the controller state and registers
  phase_t      trk_phase = PH_IDLE;
  logic [7:0]  trk_hits = '0;
  logic [7:0]  trk_holed = '0;
  logic [31:0] trk_transit_start = '0;
  logic [31:0] trk_feed_start = '0;
  logic        trk_dep = 1'b0;
  logic        trk_hole = 1'b0;
  logic        trk_gut = 1'b0;
  logic        reg_auto = 1'b0;
  logic [15:0] reg_transit = TRANSIT_TMO_RST;
  logic [15:0] reg_feed = FEED_TMO_RST;

  out_item_t expected_results[$];

  // Directed stimulus table
  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  widx;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              it;
    logic                  fixed;
    out_item_t             res;
  } dir_row_t;

  dir_row_t              dir_tab[$];
  logic                  pend_wr = 1'b0;
  logic [CFG_IDX_W-1:0]  pend_idx;
  logic [CFG_DATA_W-1:0] pend_data;

  // Stimulus controls
  bit          idle_on = 1'b1;
  bit          clears_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] clock_ms = '0;
  int          dscale = 2;

  // Tallies
  int n_items = 0, n_clears = 0, n_results = 0, n_writes = 0;
  int n_stuck = 0, n_hole_ret = 0, n_player = 0, n_mism = 0;

  // One controller step on the mirror state
  function automatic out_item_t step_tracker(input in_item_t it);
    out_item_t   o;
    logic [31:0] elapsed;
    o = '0;
    if (it.cmd == CMD_CLEAR) begin
      trk_hits  = '0;
      trk_holed = '0;
    end else begin
      if (it.departure_event) trk_dep = 1'b1;
      if (it.hole_event) trk_hole = 1'b1;
      if (it.gutter_event) trk_gut = 1'b1;
      case (trk_phase)
        PH_IDLE: begin
          if (reg_auto) trk_phase = PH_RDY_ENT;
          else trk_phase = PH_COUNT;
        end
        PH_COUNT: begin
          if (reg_auto) begin
            trk_phase = PH_RDY_ENT;
          end else begin
            if (trk_dep) begin
              trk_hits = trk_hits + 8'd1;
              trk_dep  = 1'b0;
            end
            if (trk_hole) begin
              trk_holed = trk_holed + 8'd1;
              trk_hole  = 1'b0;
              o.hole_return_request = 1'b1;
              // holes never run ahead of hits, on the wrapped values
              if (trk_holed > trk_hits) trk_holed = trk_hits;
            end
          end
        end
        PH_RDY_ENT: begin
          trk_dep = 1'b0;
          if (!reg_auto) begin
            trk_phase = PH_COUNT;
          end else begin
            o.player_return_request = 1'b1;
            trk_phase = PH_READY;
          end
        end
        PH_READY: begin
          if (trk_dep) begin
            trk_hits = trk_hits + 8'd1;
            trk_dep  = 1'b0;
            trk_transit_start = it.now_ms;
            trk_phase = PH_TR_ENT;
          end
        end
        PH_TR_ENT: begin
          trk_hole  = 1'b0;
          trk_gut   = 1'b0;
          trk_phase = PH_TRANSIT;
        end
        PH_TRANSIT: begin
          elapsed = it.now_ms - trk_transit_start;
          if (trk_hole) begin
            trk_holed = trk_holed + 8'd1;
            trk_hole  = 1'b0;
            trk_phase = PH_HOLED;
          end else if (trk_gut) begin
            // gutter flag stays set for the gutter wait
            trk_feed_start = it.now_ms;
            trk_phase = PH_GUTTER;
          end else if (elapsed > {16'd0, reg_transit}) begin
            trk_phase = PH_STUCK;
          end
        end
        PH_HOLED: begin
          o.hole_return_request = 1'b1;
          trk_feed_start = it.now_ms;
          trk_phase = PH_GUTTER;
        end
        PH_GUTTER: begin
          elapsed = it.now_ms - trk_feed_start;
          if (trk_gut) begin
            trk_gut   = 1'b0;
            trk_phase = PH_RDY_ENT;
          end else if (elapsed > {16'd0, reg_feed}) begin
            trk_phase = PH_RDY_ENT;
          end
        end
        PH_STUCK: trk_phase = PH_RDY_ENT;
        default:  trk_phase = PH_IDLE;
      endcase
    end
    o.hit_count   = trk_hits;
    o.holed_count = trk_holed;
    o.phase_now   = trk_phase;
    return o;
  endfunction

  // Random item; dispense mode steers events by the current phase so balls run full laps
  function automatic in_item_t make_item();
    in_item_t    it;
    int unsigned r;
    it = '0;
    it.cmd = CMD_RUN;
    if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, dscale);
    it.now_ms = clock_ms;
    if (!reg_auto) begin
      if (clears_on && $urandom_range(0, 99) == 0) it.cmd = CMD_CLEAR;
      it.departure_event = ($urandom_range(0, 3) != 0);
      it.hole_event      = 1'($urandom_range(0, 1));
      it.gutter_event    = ($urandom_range(0, 3) == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      // noise
      {it.departure_event, it.hole_event, it.gutter_event} = 3'($urandom);
      if ($urandom_range(0, 3) == 0) it.cmd = CMD_CLEAR;
    end else begin
      case (trk_phase)
        PH_READY: it.departure_event = ($urandom_range(0, 2) == 0);
        PH_TRANSIT: begin
          r = $urandom_range(0, 7);
          it.hole_event   = (r < 2);
          it.gutter_event = (r == 2 || r == 3);
        end
        PH_GUTTER: it.gutter_event = ($urandom_range(0, 2) == 0);
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic logic [15:0] pick_tmo();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 60));
      4:       return 16'($urandom_range(61, 3000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed table rows
  task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    pend_wr   = 1'b1;
    pend_idx  = idx;
    pend_data = data;
  endtask

  task automatic row(input logic fx, input logic cmd, input logic [31:0] now,
                     input logic [2:0] ev, input out_item_t res);
    dir_row_t r;
    r = '0;
    r.wr    = pend_wr;
    r.widx  = pend_idx;
    r.wdata = pend_data;
    r.it.cmd    = cmd;
    r.it.now_ms = now;
    {r.it.departure_event, r.it.hole_event, r.it.gutter_event} = ev;
    r.fixed = fx;
    r.res   = res;
    dir_tab.push_back(r);
    pend_wr = 1'b0;
  endtask

  // Offer one item, optionally after a gap, and predict once it is taken
  task automatic send_item(input in_item_t it, output out_item_t pred);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    pred = step_tracker(it);
    n_items++;
    if (it.cmd == CMD_CLEAR) n_clears++;
  endtask

  task automatic run_items(input int n);
    out_item_t pred;
    for (int k = 0; k < n; k++) begin
      send_item(make_item(), pred);
      expected_results.push_back(pred);
    end
  endtask

  // Stop offering and wait for every result plus the pipeline latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
    case (idx)
      CFG_AUTO_DISPENSE: reg_auto    = data[0];
      CFG_TRANSIT_TMO:   reg_transit = data;
      CFG_FEED_TMO:      reg_feed    = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_config(input bit ad, input logic [15:0] tt, input logic [15:0] ft);
    drain();
    write_reg(CFG_UNUSED_IDX, 16'($urandom), 1'b0);
    write_reg(CFG_AUTO_DISPENSE, {15'($urandom), ad}, 1'b0);
    write_reg(CFG_TRANSIT_TMO, tt, 1'b0);
    write_reg(CFG_FEED_TMO, ft, 1'b1);
    dscale = ((tt > ft) ? int'(tt) : int'(ft)) / 6 + 2;
  endtask

  // Result side: check, then plan ready for the next cycle
  int hold_left = 0;
  int stall_left = 0;
  bit hold_seen = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.item);
      // one long hold-off the first time it is asked for
      if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_result(input out_item_t got);
    out_item_t e;
    n_results++;
    if (got.phase_now == PH_STUCK) n_stuck++;
    if (got.hole_return_request) n_hole_ret++;
    if (got.player_return_request) n_player++;
    if (expected_results.size() == 0) begin
      n_mism++;
      if (n_mism <= 10)
        $display("%0t: result with nothing expected: hr=%0d pr=%0d hits=%0d holed=%0d ph=%0d",
                 $realtime, got.hole_return_request, got.player_return_request,
                 got.hit_count, got.holed_count, got.phase_now);
    end else begin
      e = expected_results.pop_front();
      if (got.hole_return_request !== e.hole_return_request ||
          got.player_return_request !== e.player_return_request ||
          got.hit_count !== e.hit_count || got.holed_count !== e.holed_count ||
          got.phase_now !== e.phase_now) begin
        n_mism++;
        if (n_mism <= 10) begin
          $write("%0t: mismatch: exp hr=%0d pr=%0d hits=%0d holed=%0d ph=%0d, ",
                 $realtime, e.hole_return_request, e.player_return_request,
                 e.hit_count, e.holed_count, e.phase_now);
          $display("got hr=%0d pr=%0d hits=%0d holed=%0d ph=%0d",
                   got.hole_return_request, got.player_return_request,
                   got.hit_count, got.holed_count, got.phase_now);
        end
      end
    end
  endtask

  // Watchdog on cycles with no handshake on either channel
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: no handshake for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    out_item_t pred;
    int        n_bad;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;

    // counting mode at reset values: extremes, clamp, clear
    row(1'b1, CMD_RUN,   32'd0,          EV_NONE, '{1'b0, 1'b0, 8'd0, 8'd0, PH_COUNT});
    row(1'b1, CMD_RUN,   32'hFFFF_FFFF,  EV_DEP | EV_HOLE | EV_GUT,
        '{1'b1, 1'b0, 8'd1, 8'd1, PH_COUNT});
    row(1'b1, CMD_RUN,   32'd1,          EV_HOLE, '{1'b1, 1'b0, 8'd1, 8'd1, PH_COUNT});
    row(1'b1, CMD_CLEAR, 32'hA5A5_5A5A,  EV_DEP | EV_HOLE | EV_GUT,
        '{1'b0, 1'b0, 8'd0, 8'd0, PH_COUNT});
    row(1'b1, CMD_RUN,   32'd2,          EV_NONE, '{1'b0, 1'b0, 8'd0, 8'd0, PH_COUNT});
    // dispense mode: stuck ball at the transit limit
    row_cfg(CFG_AUTO_DISPENSE, 16'h0001);
    row(1'b1, CMD_RUN,   32'd3,          EV_DEP,  '{1'b0, 1'b0, 8'd0, 8'd0, PH_RDY_ENT});
    row(1'b1, CMD_RUN,   32'd4,          EV_NONE, '{1'b0, 1'b1, 8'd0, 8'd0, PH_READY});
    row(1'b0, CMD_RUN,   32'd1000,       EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd1000,       EV_DEP,  '0);
    row(1'b0, CMD_RUN,   32'd1100,       EV_HOLE | EV_GUT, '0);
    row(1'b0, CMD_RUN,   32'd6000,       EV_NONE, '0);
    row(1'b1, CMD_RUN,   32'd6001,       EV_NONE, '{1'b0, 1'b0, 8'd1, 8'd0, PH_STUCK});
    row_cfg(CFG_UNUSED_IDX, 16'hFFFF);
    row(1'b0, CMD_RUN,   32'd6002,       EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd6003,       EV_NONE, '0);
    // holed ball across the timestamp wrap, feed times out at the limit
    row(1'b0, CMD_RUN,   32'hFFFF_FF00,  EV_DEP,  '0);
    row(1'b0, CMD_RUN,   32'hFFFF_FF10,  EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd16,         EV_HOLE, '0);
    row(1'b0, CMD_RUN,   32'd32,         EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd7032,       EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd7033,       EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd7034,       EV_NONE, '0);
    // gutter straight from transit: flag carries into the gutter wait
    row(1'b0, CMD_RUN,   32'd7035,       EV_DEP,  '0);
    row(1'b0, CMD_RUN,   32'd7036,       EV_NONE, '0);
    row(1'b0, CMD_RUN,   32'd7037,       EV_GUT,  '0);
    row(1'b0, CMD_RUN,   32'd7038,       EV_NONE, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        drain();
        write_reg(dir_tab[i].widx, dir_tab[i].wdata, 1'b1);
      end
      send_item(dir_tab[i].it, pred);
      expected_results.push_back(dir_tab[i].fixed ? dir_tab[i].res : pred);
    end

    // long counting run without clears so the counters wrap
    set_config(1'b0, TRANSIT_TMO_RST, FEED_TMO_RST);
    clears_on = 1'b0;
    run_items(380);
    clears_on = 1'b1;
    run_items(120);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       set_config(1'b1, 16'd0, 16'd0);
        1:       set_config(1'b1, 16'hFFFF, 16'hFFFF);
        5:       set_config(1'b0, pick_tmo(), pick_tmo());
        default: set_config($urandom_range(0, 4) != 0, pick_tmo(), pick_tmo());
      endcase
      if (ph == 2) clock_ms = 32'hFFFF_F000;
      idle_on = (ph % 4 != 2);
      // receiver holds off while the sender keeps offering
      if (ph == 3) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      run_items(120);
    end

    // closing stretch at full rate
    set_config(1'b1, 16'd40, 16'd25);
    idle_on = 1'b0;
    run_items(150);

    drain();
    repeat (5) @(posedge clk);
    n_bad = n_mism + expected_results.size();

    $display("tb: %0d items (%0d clears), %0d results checked, %0d register writes",
             n_items, n_clears, n_results, n_writes);
    $display("tb: %0d stuck balls, %0d hole returns, %0d player returns, %0d mismatches",
             n_stuck, n_hole_ret, n_player, n_bad);
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
